@@ sv/psd_pkg.sv @@
package psd_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int DIST_BITS = 25;
	localparam int FRAC_SHIFT = 16;
	localparam logic [15:0] LIMIT_RESET = 16'd1;

	typedef enum logic [1:0] {
		CASE_INTERIOR = 2'd0,
		CASE_START    = 2'd1,
		CASE_END      = 2'd2,
		CASE_DEGEN    = 2'd3
	} nearest_case_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
	} query_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] distance_q8;
		nearest_case_t        nearest_case;
	} result_t;

endpackage

@@ sv/point_to_segment_distance.sv @@
// Point to line segment distance, one query word per cycle unless stalled.
// A query word (point, segment start, segment end) is taken on a clock edge
// with query_valid high and query_stall low. The result word carries the
// distance in unsigned fixed point with 8 fraction bits, floored, and the
// case that applied (interior, start, end or degenerate segment).
// Segments whose squared length is below the limit register count as the
// start point. The user must write the register with cfg_write and cfg_data
// only while no query is in flight; the block does not enforce this.
// The pipeline has five arithmetic stages followed by one stage per
// result bit of the square root, each a shift, add and compare.
// Throughput is one word per cycle unless stalled. When result_stall is
// held while a result is shown, the whole pipeline freezes and query_stall
// is raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets the limit to one.
module point_to_segment_distance import psd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    query_valid,
	output logic    query_stall,
	input  query_t  query,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result,
	input  logic    cfg_write,
	input  logic [15:0] cfg_data
);

	localparam int W  = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;
	localparam int CW = 2 * W + 2;
	localparam int H  = CW / 2;
	localparam int LB = 2 * W + 2;
	localparam int NB = 4 * W + 19;
	localparam int TA = 50 + LB;
	localparam int TW = ((NB > TA) ? NB : TA) + 1;
	localparam int RS = DIST_BITS;

	logic [15:0] limit_q;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_write) begin
			limit_q <= cfg_data;
		end
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic [RS:0] rv_s;

	assign adv = !rv_s[RS] || !result_stall;
	assign query_stall = !adv;

	logic signed [DW-1:0] ax_s1, ay_s1, lx_s1, ly_s1, bx_s1, by_s1;
	logic signed [PW-1:0] lxx_s2, lyy_s2, axlx_s2, ayly_s2, axly_s2, aylx_s2;
	logic signed [PW-1:0] axx_s2, ayy_s2, bxx_s2, byy_s2;
	logic [LB-1:0] lsq_s3, da_s3, db_s3;
	logic signed [SW-1:0] dot_s3;
	logic [CW-1:0] cmag_s3;
	nearest_case_t kase_s4;
	logic [NB-1:0] seln_s4;
	logic [LB-1:0] lsq_s4;
	logic [2*H-1:0] ll_s4, lh_s4, hh_s4;

	logic [TW-1:0] rt_t_s [0:RS];
	logic [TW-1:0] rt_u_s [0:RS];
	logic [TW-1:0] rt_n_s [0:RS];
	logic [TW-1:0] rt_l_s [0:RS];
	logic [RS-1:0] rt_r_s [0:RS];
	nearest_case_t rt_c_s [0:RS];
	logic [TW-1:0] trial [0:RS-1];

	logic signed [SW-1:0] cross_c;
	nearest_case_t kase_c;
	logic [NB-1:0] comb_c;

	always_comb begin
		cross_c = SW'(axly_s2) - SW'(aylx_s2);
	end

	always_comb begin
		priority if (lsq_s3 < LB'(limit_q)) begin
			kase_c = CASE_DEGEN;
		end else if (dot_s3 <= 0) begin
			kase_c = CASE_START;
		end else if (dot_s3 >= $signed({1'b0, lsq_s3})) begin
			kase_c = CASE_END;
		end else begin
			kase_c = CASE_INTERIOR;
		end
	end

	always_comb begin
		comb_c = ((NB'(hh_s4) << (2 * H)) + (NB'(lh_s4) << (H + 1)) + NB'(ll_s4))
			<< FRAC_SHIFT;
	end

	always_comb begin
		for (int k = 0; k < RS; k++) begin
			trial[k] = rt_t_s[k] + (rt_u_s[k] << (RS - k)) + (rt_l_s[k] << (2 * (RS - 1 - k)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			rv_s <= '0;
		end else if (adv) begin
			v_s1 <= query_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			rv_s <= {rv_s[RS-1:0], v_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= DW'(query.point_x) - DW'(query.start_x);
			ay_s1 <= DW'(query.point_y) - DW'(query.start_y);
			lx_s1 <= DW'(query.end_x) - DW'(query.start_x);
			ly_s1 <= DW'(query.end_y) - DW'(query.start_y);
			bx_s1 <= DW'(query.point_x) - DW'(query.end_x);
			by_s1 <= DW'(query.point_y) - DW'(query.end_y);

			lxx_s2  <= lx_s1 * lx_s1;
			lyy_s2  <= ly_s1 * ly_s1;
			axlx_s2 <= ax_s1 * lx_s1;
			ayly_s2 <= ay_s1 * ly_s1;
			axly_s2 <= ax_s1 * ly_s1;
			aylx_s2 <= ay_s1 * lx_s1;
			axx_s2  <= ax_s1 * ax_s1;
			ayy_s2  <= ay_s1 * ay_s1;
			bxx_s2  <= bx_s1 * bx_s1;
			byy_s2  <= by_s1 * by_s1;

			lsq_s3  <= LB'($unsigned(lxx_s2)) + LB'($unsigned(lyy_s2));
			da_s3   <= LB'($unsigned(axx_s2)) + LB'($unsigned(ayy_s2));
			db_s3   <= LB'($unsigned(bxx_s2)) + LB'($unsigned(byy_s2));
			dot_s3  <= SW'(axlx_s2) + SW'(ayly_s2);
			cmag_s3 <= cross_c[SW-1] ? CW'(-cross_c) : CW'(cross_c);

			kase_s4 <= kase_c;
			seln_s4 <= (kase_c == CASE_END) ? (NB'(db_s3) << FRAC_SHIFT)
				: (NB'(da_s3) << FRAC_SHIFT);
			lsq_s4  <= lsq_s3;
			ll_s4   <= cmag_s3[H-1:0] * cmag_s3[H-1:0];
			lh_s4   <= cmag_s3[H-1:0] * cmag_s3[CW-1:H];
			hh_s4   <= cmag_s3[CW-1:H] * cmag_s3[CW-1:H];

			rt_t_s[0] <= '0;
			rt_u_s[0] <= '0;
			rt_r_s[0] <= '0;
			rt_c_s[0] <= kase_s4;
			rt_n_s[0] <= (kase_s4 == CASE_INTERIOR) ? TW'(comb_c) : TW'(seln_s4);
			rt_l_s[0] <= (kase_s4 == CASE_INTERIOR) ? TW'(lsq_s4) : TW'(1);

			for (int k = 0; k < RS; k++) begin
				rt_n_s[k+1] <= rt_n_s[k];
				rt_l_s[k+1] <= rt_l_s[k];
				rt_c_s[k+1] <= rt_c_s[k];
				if (trial[k] <= rt_n_s[k]) begin
					rt_t_s[k+1] <= trial[k];
					rt_u_s[k+1] <= rt_u_s[k] + (rt_l_s[k] << (RS - 1 - k));
					rt_r_s[k+1] <= rt_r_s[k] | (RS'(1) << (RS - 1 - k));
				end else begin
					rt_t_s[k+1] <= rt_t_s[k];
					rt_u_s[k+1] <= rt_u_s[k];
					rt_r_s[k+1] <= rt_r_s[k];
				end
			end
		end
	end

	assign result_valid = rv_s[RS];
	assign result.distance_q8 = rt_r_s[RS];
	assign result.nearest_case = rt_c_s[RS];

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		query_stall == (result_valid && result_stall))
		else $error("query_stall does not follow the output stall");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (rt_t_s[RS] <= rt_n_s[RS]))
		else $error("square root overshoots its operand");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(rv_s) && $stable(v_s4))
		else $error("pipeline moved while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_s[0] && rt_c_s[0] != CASE_INTERIOR) |-> (rt_l_s[0] == TW'(1)))
		else $error("endpoint case entered root with a length divisor");

endmodule
